/* rtl/bpsl_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, operation codes, state encoding and the command/status
// structs passed between the controller and the datapath of the sorted list.
// No dependencies.
package bpsl_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned PRIO_W = 16;
  localparam int unsigned PAY_W  = 32;
  localparam int unsigned FUNC_W = 2;
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned CW     = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W  = ((IDX_W > CW) ? IDX_W : CW) + 1;

  typedef enum logic [FUNC_W-1:0] {
    OP_INSERT = FUNC_W'(0),
    OP_REMOVE = FUNC_W'(1),
    OP_READ   = FUNC_W'(2)
  } bpsl_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_INS_WALK,
    ST_INS_PUT,
    ST_REM_WALK,
    ST_REM_END,
    ST_RD_WAIT,
    ST_DONE
  } bpsl_state_e;

  typedef struct packed {
    logic load;
    logic ins_init;
    logic ins_step;
    logic ins_put;
    logic rem_init;
    logic rem_step;
    logic rem_end;
    logic rd_init;
    logic rd_take;
    logic finish;
  } bpsl_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              idx_ok;
    logic              ins_empty;
    logic              ins_shift;
    logic              ptr_zero;
    logic              rem_none;
    logic              rem_more;
    logic              out_free;
  } bpsl_sts_t;

endpackage

/* rtl/bpsl_ctrl.sv */
`timescale 1ns / 1ps
// Controller of the sorted list: sequences insert, remove and read requests.
// Depends on bpsl_pkg; drives bpsl_dpath through bpsl_cmd_t.
module bpsl_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bpsl_pkg::bpsl_sts_t sts_i,
  output bpsl_pkg::bpsl_cmd_t cmd_o
);
  import bpsl_pkg::*;

  bpsl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_LAUNCH;
      end
      ST_LAUNCH: begin
        unique case (sts_i.func)
          OP_INSERT: state_d = sts_i.ins_empty ? ST_INS_PUT : ST_INS_WALK;
          OP_REMOVE: begin
            if (!sts_i.idx_ok) state_d = ST_DONE;
            else state_d = sts_i.rem_none ? ST_REM_END : ST_REM_WALK;
          end
          OP_READ:   state_d = sts_i.idx_ok ? ST_RD_WAIT : ST_DONE;
          default:   state_d = ST_DONE;
        endcase
      end
      ST_INS_WALK: begin
        if (!sts_i.ins_shift) state_d = ST_DONE;
        else if (sts_i.ptr_zero) state_d = ST_INS_PUT;
      end
      ST_INS_PUT: state_d = ST_DONE;
      ST_REM_WALK: begin
        if (!sts_i.rem_more) state_d = ST_REM_END;
      end
      ST_REM_END: state_d = ST_DONE;
      ST_RD_WAIT: state_d = ST_DONE;
      ST_DONE: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.load   = in_valid_i;
      end
      ST_LAUNCH: begin
        unique case (sts_i.func)
          OP_INSERT: cmd_o.ins_init = 1'b1;
          OP_REMOVE: cmd_o.rem_init = sts_i.idx_ok;
          OP_READ:   cmd_o.rd_init  = sts_i.idx_ok;
          default:   cmd_o          = '0;
        endcase
      end
      ST_INS_WALK: cmd_o.ins_step = 1'b1;
      ST_INS_PUT:  cmd_o.ins_put  = 1'b1;
      ST_REM_WALK: cmd_o.rem_step = 1'b1;
      ST_REM_END:  cmd_o.rem_end  = 1'b1;
      ST_RD_WAIT:  cmd_o.rd_take  = 1'b1;
      ST_DONE:     cmd_o.finish   = sts_i.out_free;
      default:     cmd_o          = '0;
    endcase
  end

endmodule

/* rtl/bpsl_dpath.sv */
`timescale 1ns / 1ps
// Datapath of the sorted list: entry memory, count, walk pointer and result
// register. Depends on bpsl_pkg; commanded by bpsl_ctrl.
module bpsl_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bpsl_pkg::bpsl_cmd_t           cmd_i,
  output bpsl_pkg::bpsl_sts_t           sts_o,
  input  logic [bpsl_pkg::FUNC_W-1:0]   func_i,
  input  logic [bpsl_pkg::IDX_W-1:0]    index_i,
  input  logic [bpsl_pkg::PRIO_W-1:0]   priority_req_i,
  input  logic [bpsl_pkg::PAY_W-1:0]    payload_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          ok_o,
  output logic                          evicted_o,
  output logic [bpsl_pkg::CNT_W-1:0]    entry_count_o,
  output logic [bpsl_pkg::PRIO_W-1:0]   read_priority_o,
  output logic [bpsl_pkg::PAY_W-1:0]    read_payload_o
);
  import bpsl_pkg::*;

  logic [PRIO_W-1:0] prio_mem [DEPTH];
  logic [PAY_W-1:0]  pay_mem  [DEPTH];

  logic [FUNC_W-1:0] func_q;
  logic [IDX_W-1:0]  index_q;
  logic [PRIO_W-1:0] prio_q;
  logic [PAY_W-1:0]  pay_q;
  logic [CW-1:0]     held_q, held_d;
  logic [AW-1:0]     ptr_q, ptr_d;
  logic              evict_q, ok_q;
  logic [PRIO_W-1:0] rprio_q, rd_prio_q;
  logic [PAY_W-1:0]  rpay_q, rd_pay_q;
  logic              out_valid_q;
  logic              out_ok_q, out_evict_q;
  logic [CNT_W-1:0]  out_cnt_q;
  logic [PRIO_W-1:0] out_prio_q;
  logic [PAY_W-1:0]  out_pay_q;

  logic              held_full;
  logic [CW-1:0]     held_eff, heff_m1;
  logic [CMP_W-1:0]  idx_x, idx_p1, held_x, ptr_x;
  logic              rd_en, we;
  logic [AW-1:0]     rd_addr, wa;
  logic [PRIO_W-1:0] wd_prio;
  logic [PAY_W-1:0]  wd_pay;

  assign held_full = (held_q == CW'(DEPTH));
  assign held_eff  = held_full ? CW'(DEPTH - 1) : held_q;
  assign heff_m1   = held_eff - CW'(1);
  assign idx_x     = CMP_W'(index_q);
  assign idx_p1    = idx_x + CMP_W'(1);
  assign held_x    = CMP_W'(held_q);
  assign ptr_x     = CMP_W'(ptr_q);

  always_comb begin
    sts_o.func      = func_q;
    sts_o.idx_ok    = (idx_x < held_x);
    sts_o.ins_empty = (held_eff == '0);
    sts_o.ins_shift = (rd_prio_q <= prio_q);
    sts_o.ptr_zero  = (ptr_q == '0);
    sts_o.rem_none  = (idx_p1 >= held_x);
    sts_o.rem_more  = ((ptr_x + CMP_W'(1)) < held_x);
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ptr_q;
    we      = 1'b0;
    wa      = ptr_q;
    wd_prio = rd_prio_q;
    wd_pay  = rd_pay_q;
    if (cmd_i.ins_init && !sts_o.ins_empty) begin
      rd_en   = 1'b1;
      rd_addr = heff_m1[AW-1:0];
    end
    if (cmd_i.ins_step) begin
      we = 1'b1;
      wa = ptr_q + AW'(1);
      if (sts_o.ins_shift) begin
        if (!sts_o.ptr_zero) begin
          rd_en   = 1'b1;
          rd_addr = ptr_q - AW'(1);
        end
      end else begin
        wd_prio = prio_q;
        wd_pay  = pay_q;
      end
    end
    if (cmd_i.ins_put) begin
      we      = 1'b1;
      wa      = ptr_q;
      wd_prio = prio_q;
      wd_pay  = pay_q;
    end
    if (cmd_i.rem_init && !sts_o.rem_none) begin
      rd_en   = 1'b1;
      rd_addr = idx_p1[AW-1:0];
    end
    if (cmd_i.rem_step) begin
      we = 1'b1;
      wa = ptr_q - AW'(1);
      if (sts_o.rem_more) begin
        rd_en   = 1'b1;
        rd_addr = ptr_q + AW'(1);
      end
    end
    if (cmd_i.rd_init) begin
      rd_en   = 1'b1;
      rd_addr = idx_x[AW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      prio_mem[wa] <= wd_prio;
      pay_mem[wa]  <= wd_pay;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_prio_q <= prio_mem[rd_addr];
      rd_pay_q  <= pay_mem[rd_addr];
    end
  end

  always_comb begin
    held_d = held_q;
    if (cmd_i.ins_init && held_full) held_d = CW'(DEPTH - 1);
    if ((cmd_i.ins_step && !sts_o.ins_shift) || cmd_i.ins_put) held_d = held_q + CW'(1);
    if (cmd_i.rem_end) held_d = held_q - CW'(1);
  end

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.ins_init) ptr_d = sts_o.ins_empty ? '0 : heff_m1[AW-1:0];
    if (cmd_i.ins_step && sts_o.ins_shift && !sts_o.ptr_zero) ptr_d = ptr_q - AW'(1);
    if (cmd_i.rem_init) ptr_d = idx_p1[AW-1:0];
    if (cmd_i.rem_step && sts_o.rem_more) ptr_d = ptr_q + AW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      held_q <= held_d;
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    if (cmd_i.load) begin
      func_q  <= func_i;
      index_q <= index_i;
      prio_q  <= priority_req_i;
      pay_q   <= payload_i;
      evict_q <= 1'b0;
      ok_q    <= 1'b0;
      rprio_q <= '0;
      rpay_q  <= '0;
    end
    if (cmd_i.ins_init && held_full) evict_q <= 1'b1;
    if ((cmd_i.ins_step && !sts_o.ins_shift) || cmd_i.ins_put || cmd_i.rem_end) begin
      ok_q <= 1'b1;
    end
    if (cmd_i.rd_take) begin
      ok_q    <= 1'b1;
      rprio_q <= rd_prio_q;
      rpay_q  <= rd_pay_q;
    end
    if (cmd_i.finish) begin
      out_ok_q    <= ok_q;
      out_evict_q <= evict_q;
      out_cnt_q   <= CNT_W'(held_q);
      out_prio_q  <= rprio_q;
      out_pay_q   <= rpay_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign ok_o            = out_ok_q;
  assign evicted_o       = out_evict_q;
  assign entry_count_o   = out_cnt_q;
  assign read_priority_o = out_prio_q;
  assign read_payload_o  = out_pay_q;

endmodule

/* rtl/bounded_priority_sorted_list.sv */
`timescale 1ns / 1ps
// Bounded list of up to DEPTH entries (priority, payload) kept in descending
// priority order; insert, remove at index and read at index, one request at a
// time. Entries live in a single-port-read, single-port-write memory that is
// walked one entry per cycle. Each request passes through a launch step; an
// insert walks the entries it moves and puts the new entry, a remove walks the
// entries it moves and ends with an end step, a read waits on the memory, and
// a read or remove past the count or an unknown operation goes straight on.
// All end in a done step. The result is presented in the cycle in which ready
// returns. A finished result waits in an output register while the next
// request is accepted; the block holds in its last step while that register
// is still untaken. Depends on bpsl_pkg, bpsl_ctrl and bpsl_dpath.
module bounded_priority_sorted_list (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [bpsl_pkg::FUNC_W-1:0] func_i,
  input  logic [bpsl_pkg::IDX_W-1:0]  index_i,
  input  logic [bpsl_pkg::PRIO_W-1:0] priority_req_i,
  input  logic [bpsl_pkg::PAY_W-1:0]  payload_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        ok_o,
  output logic                        evicted_o,
  output logic [bpsl_pkg::CNT_W-1:0]  entry_count_o,
  output logic [bpsl_pkg::PRIO_W-1:0] read_priority_o,
  output logic [bpsl_pkg::PAY_W-1:0]  read_payload_o
);
  import bpsl_pkg::*;

  bpsl_cmd_t cmd;
  bpsl_sts_t sts;

  bpsl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bpsl_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .func_i          (func_i),
    .index_i         (index_i),
    .priority_req_i  (priority_req_i),
    .payload_i       (payload_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .ok_o            (ok_o),
    .evicted_o       (evicted_o),
    .entry_count_o   (entry_count_o),
    .read_priority_o (read_priority_o),
    .read_payload_o  (read_payload_o)
  );

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while previous one still in progress");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> read_priority_o == '0 && read_payload_o == '0)
    else $error("failed request carries read data");

  a_evict_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && evicted_o |-> ok_o && entry_count_o == CNT_W'(DEPTH))
    else $error("eviction without a full list");

  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> sts.out_free)
    else $error("result loaded over an untaken result");

endmodule
